[src/aemb_pkg.sv]
// Shared types and constants for the AXI exclusive monitor with burst address generation.
`default_nettype none

package aemb_pkg;

   // Field widths fixed by the AXI beat description.
   localparam int ADDR_WIDTH      = 64;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int PAGE_LSB        = 12;
   localparam int WRAP_LSB_WIDTH  = 11;
   localparam int REM_BITS        = 8;

   // Beat direction codes.
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // Burst modes; fixed and the reserved code share the default path.
   localparam logic [1:0] MODE_INCR = 2'd1;
   localparam logic [1:0] MODE_WRAP = 2'd2;

   // Response codes.
   localparam logic [1:0] RSP_OK      = 2'd0;
   localparam logic [1:0] RSP_EXCL_OK = 2'd1;
   localparam logic [1:0] RSP_DEC_ERR = 2'd2;

   // One accepted AXI beat.
   typedef struct packed {
      logic                  operation;
      logic [ADDR_WIDTH-1:0] base_address;
      logic [1:0]            beat_size;
      logic [1:0]            burst_mode;
      logic [7:0]            burst_length;
      logic [7:0]            beat_number;
      logic                  exclusive;
   } aemb_req_type;

   // Result of one beat.
   typedef struct packed {
      logic [ADDR_WIDTH-1:0] beat_address;
      logic [1:0]            target_index;
      logic                  address_ok;
      logic                  write_enable;
      logic [1:0]            response;
   } aemb_rsp_type;

   // Operands of the shared adder and comparator.
   typedef struct packed {
      logic [ADDR_WIDTH-1:0] a;
      logic [ADDR_WIDTH-1:0] b;
      logic [ADDR_WIDTH-1:0] c;
      logic                  sub;
   } aemb_alu_in_type;

   // Result of the shared unit: a signed 65-bit sum and the compare flag.
   typedef struct packed {
      logic [ADDR_WIDTH:0] result;
      logic                below;
   } aemb_alu_out_type;

   // One window as seen by the decoder.
   typedef struct packed {
      logic [ADDR_WIDTH-1:0] base;
      logic [ADDR_WIDTH-1:0] span;
   } aemb_win_type;

   // Overlap check request for the reservation entry being scanned.
   typedef struct packed {
      logic                check;
      logic [ADDR_WIDTH:0] diff;
      logic [1:0]          beat_size;
   } aemb_probe_type;

   // New reservation from an exclusive read.
   typedef struct packed {
      logic                  reserve;
      logic [ADDR_WIDTH-1:0] address;
      logic [1:0]            size;
   } aemb_commit_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REMAIN,
      ST_ADDRESS,
      ST_WINDOW,
      ST_TABLE,
      ST_FINISH
   } aemb_state_type;

endpackage

`default_nettype wire

[src/aemb_alu.sv]
// Shared 64-bit adder/subtractor with a magnitude compare on its result.
`default_nettype none

module aemb_alu (
   input  aemb_pkg::aemb_alu_in_type  alu_in,
   output aemb_pkg::aemb_alu_out_type alu_out
);
   import aemb_pkg::*;

   localparam int SUM_WIDTH = ADDR_WIDTH + 1;

   logic [SUM_WIDTH-1:0] operand_b;
   logic [SUM_WIDTH-1:0] sum;

   // Subtraction adds the inverted operand plus one; the top bit is the sign.
   always_comb begin
      operand_b = alu_in.sub ? ~{1'b0, alu_in.b} : {1'b0, alu_in.b};
      sum       = {1'b0, alu_in.a} + operand_b + SUM_WIDTH'(alu_in.sub);
   end

   // The compare looks at the low 64 bits, as the window test is modulo 2^64.
   assign alu_out.result = sum;
   assign alu_out.below  = sum[ADDR_WIDTH-1:0] < alu_in.c;

endmodule

`default_nettype wire

[src/aemb_win.sv]
// Target window registers with the configuration write port and a scan read port.
`default_nettype none

module aemb_win #(
   parameter  int TARGET_WINDOWS = 4,
   localparam int WIN_IDX_W      = (TARGET_WINDOWS > 1) ? $clog2(TARGET_WINDOWS) : 1
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   input  logic [aemb_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [aemb_pkg::ADDR_WIDTH-1:0]       csr_data,
   input  logic [WIN_IDX_W-1:0]                  rd_index,
   output aemb_pkg::aemb_win_type                rd_window
);
   import aemb_pkg::*;

   localparam int SLOT_W = CSR_INDEX_WIDTH - 1;

   logic [ADDR_WIDTH-1:0] base_ff [TARGET_WINDOWS];
   logic [ADDR_WIDTH-1:0] span_ff [TARGET_WINDOWS];
   logic [SLOT_W-1:0]     csr_slot;
   logic                  csr_hit;

   // Odd indexes carry spans, even ones bases; slots past the last window are dropped.
   assign csr_slot = csr_index[CSR_INDEX_WIDTH-1:1];
   assign csr_hit  = csr_valid && ({1'b0, csr_slot} < (SLOT_W + 1)'(TARGET_WINDOWS));

   // Window registers reset to zero, which leaves every window disabled.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < TARGET_WINDOWS; k++) begin
            base_ff[k] <= '0;
            span_ff[k] <= '0;
         end
      end else if (csr_hit) begin
         if (csr_index[0]) begin
            span_ff[WIN_IDX_W'(csr_slot)] <= csr_data;
         end else begin
            base_ff[WIN_IDX_W'(csr_slot)] <= csr_data;
         end
      end
   end

   // The sequencer reads one window per cycle.
   assign rd_window.base = base_ff[rd_index];
   assign rd_window.span = span_ff[rd_index];

endmodule

`default_nettype wire

[src/aemb_resv.sv]
// Exclusive reservation table: entries, valid bits, round-robin pointer and overlap clearing.
`default_nettype none

module aemb_resv #(
   parameter  int ENTRIES   = 4,
   localparam int ENT_IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [ENT_IDX_W-1:0]               rd_index,
   input  aemb_pkg::aemb_probe_type           probe,
   input  aemb_pkg::aemb_commit_type          commit,
   output logic [aemb_pkg::ADDR_WIDTH-1:0]    rd_address,
   output logic                               hit
);
   import aemb_pkg::*;

   // Sizes are at most 8 bytes, so overlapping ranges differ only in the low bits.
   localparam int NEAR_BITS = 4;

   logic [ENTRIES-1:0]    valid_ff;
   logic [ADDR_WIDTH-1:0] addr_ff [ENTRIES];
   logic [1:0]            size_ff [ENTRIES];
   logic [ENT_IDX_W-1:0]  ptr_ff;
   logic [ENT_IDX_W-1:0]  ptr_in;

   logic                  free_found;
   logic [ENT_IDX_W-1:0]  free_idx;
   logic [ENT_IDX_W-1:0]  slot;
   logic [NEAR_BITS-1:0]  beat_bytes;
   logic [NEAR_BITS-1:0]  entry_bytes;
   logic [NEAR_BITS:0]    near_sum;
   logic                  ahead;
   logic                  behind;
   logic                  clear;

   // Lowest free entry; when the table is full the round-robin pointer picks the victim.
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (!valid_ff[i] && !free_found) begin
            free_found = 1'b1;
            free_idx   = ENT_IDX_W'(i);
         end
      end
      slot   = free_found ? free_idx : ptr_ff;
      ptr_in = (ptr_ff == ENT_IDX_W'(ENTRIES - 1)) ? '0 : ptr_ff + 1'b1;
   end

   // The diff is entry address minus beat address, signed over 65 bits.
   // Entry at or above the beat: overlap when the distance is below the beat's bytes.
   // Entry below the beat: overlap when the distance is below the entry's bytes.
   always_comb begin
      beat_bytes  = NEAR_BITS'(1) << probe.beat_size;
      entry_bytes = NEAR_BITS'(1) << size_ff[rd_index];
      near_sum    = {1'b0, probe.diff[NEAR_BITS-1:0]} + {1'b0, entry_bytes};
      ahead       = !probe.diff[ADDR_WIDTH] && (probe.diff[ADDR_WIDTH-1:NEAR_BITS] == '0)
                    && (probe.diff[NEAR_BITS-1:0] < beat_bytes);
      behind      = probe.diff[ADDR_WIDTH] && (&probe.diff[ADDR_WIDTH-1:NEAR_BITS])
                    && near_sum[NEAR_BITS] && (near_sum[NEAR_BITS-1:0] != '0);
      clear       = probe.check && valid_ff[rd_index] && (ahead || behind);
   end

   assign rd_address = addr_ff[rd_index];
   assign hit        = valid_ff[rd_index] && (probe.diff == '0);

   // Valid bits and the replacement pointer.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         ptr_ff   <= '0;
      end else if (commit.reserve) begin
         valid_ff[slot] <= 1'b1;
         if (!free_found) begin
            ptr_ff <= ptr_in;
         end
      end else if (clear) begin
         valid_ff[rd_index] <= 1'b0;
      end
   end

   // Entry contents only matter while the entry is valid.
   always_ff @(posedge clock) begin
      if (commit.reserve) begin
         addr_ff[slot] <= commit.address;
         size_ff[slot] <= commit.size;
      end
   end

endmodule

`default_nettype wire

[src/axi_exclusive_monitor_burst.sv]
// Top level: beat sequencer around the shared adder, window registers and reservation table.
`default_nettype none

// AXI exclusive access monitor with burst beat address generation. One beat is taken
// at a time; req_stall stays high from the accepting edge until the beat's result is
// loaded into the output register, and a waiting result does not block the next beat.
// All arithmetic goes through one shared 64-bit adder and comparator, so a beat runs
// in steps: for a wrapping burst one remainder step per beat-number bit, then the
// address step, one window test per window examined (1 to TARGET_WINDOWS, stopping
// at the first match), a scan of every reservation entry for a decoded write beat,
// and the finishing step. A non-wrapping read hitting window zero is shortest.
// Window registers are written through the csr_ port, which is always ready and must
// only be used while no beat is in flight. No clearing pass follows reset.
module axi_exclusive_monitor_burst #(
   parameter int RESERVATION_ENTRIES = 4,
   parameter int TARGET_WINDOWS      = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  aemb_pkg::aemb_req_type               req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output aemb_pkg::aemb_rsp_type               rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [aemb_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [aemb_pkg::ADDR_WIDTH-1:0]      csr_data
);
   import aemb_pkg::*;

   localparam int WIN_IDX_W  = (TARGET_WINDOWS > 1) ? $clog2(TARGET_WINDOWS) : 1;
   localparam int ENT_IDX_W  = (RESERVATION_ENTRIES > 1) ? $clog2(RESERVATION_ENTRIES) : 1;
   localparam int BIT_IDX_W  = $clog2(REM_BITS);
   localparam int WRAP_LEN_W = WRAP_LSB_WIDTH + 1;

   aemb_state_type          state_ff, state_in;
   aemb_req_type            req_ff, req_in;
   logic [REM_BITS-1:0]     rem_ff, rem_in;
   logic [BIT_IDX_W-1:0]    bit_ff, bit_in;
   logic [ADDR_WIDTH-1:0]   addr_ff, addr_in;
   logic [WIN_IDX_W-1:0]    win_ff, win_in;
   logic                    found_ff, found_in;
   logic [1:0]              target_ff, target_in;
   logic [ENT_IDX_W-1:0]    ent_ff, ent_in;
   logic                    hit_ff, hit_in;
   aemb_rsp_type            rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic [REM_BITS:0]       divisor;
   logic [REM_BITS:0]       rem_shift;
   logic [WRAP_LEN_W-1:0]   wrap_len;
   logic [WRAP_LSB_WIDTH-1:0] wrap_lsb_mask;
   logic [ADDR_WIDTH-1:0]   wrap_base;
   logic [WRAP_LSB_WIDTH-1:0] wrap_offset;
   logic [WRAP_LSB_WIDTH-1:0] incr_offset;
   logic                    page_same;
   logic                    addr_ok;
   logic                    out_free;

   aemb_alu_in_type         alu_in;
   aemb_alu_out_type        alu_out;
   aemb_win_type            win_rd;
   aemb_probe_type          probe;
   aemb_commit_type         commit;
   logic [ADDR_WIDTH-1:0]   entry_address;
   logic                    entry_hit;

   // Shared arithmetic unit.
   aemb_alu u_alu (
      .alu_in  (alu_in),
      .alu_out (alu_out)
   );

   // Window registers.
   aemb_win #(
      .TARGET_WINDOWS (TARGET_WINDOWS)
   ) u_win (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rd_index  (win_ff),
      .rd_window (win_rd)
   );

   // Reservation table.
   aemb_resv #(
      .ENTRIES (RESERVATION_ENTRIES)
   ) u_resv (
      .clock      (clock),
      .reset      (reset),
      .rd_index   (ent_ff),
      .probe      (probe),
      .commit     (commit),
      .rd_address (entry_address),
      .hit        (entry_hit)
   );

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Burst geometry. A wrap offset is (beat mod beats) scaled by the beat size.
   always_comb begin
      divisor       = {1'b0, req_ff.burst_length} + {{REM_BITS{1'b0}}, 1'b1};
      rem_shift     = {rem_ff, req_ff.beat_number[bit_ff]};
      wrap_len      = WRAP_LEN_W'(divisor) << req_ff.beat_size;
      wrap_lsb_mask = WRAP_LSB_WIDTH'(wrap_len - WRAP_LEN_W'(1));
      wrap_base     = {req_ff.base_address[ADDR_WIDTH-1:WRAP_LSB_WIDTH],
                       req_ff.base_address[WRAP_LSB_WIDTH-1:0] & ~wrap_lsb_mask};
      wrap_offset   = WRAP_LSB_WIDTH'(rem_ff) << req_ff.beat_size;
      incr_offset   = WRAP_LSB_WIDTH'(req_ff.beat_number) << req_ff.beat_size;
   end

   assign page_same = (addr_ff[ADDR_WIDTH-1:PAGE_LSB]
                       == req_ff.base_address[ADDR_WIDTH-1:PAGE_LSB]);
   assign addr_ok   = found_ff && page_same;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Operand selection for the shared unit in each step.
   always_comb begin
      alu_in = '0;
      case (state_ff)
         ST_REMAIN: begin
            alu_in.a   = ADDR_WIDTH'(rem_shift);
            alu_in.b   = ADDR_WIDTH'(divisor);
            alu_in.sub = 1'b1;
         end
         ST_ADDRESS: begin
            case (req_ff.burst_mode)
               MODE_INCR: begin
                  alu_in.a = req_ff.base_address;
                  alu_in.b = ADDR_WIDTH'(incr_offset);
               end
               MODE_WRAP: begin
                  alu_in.a = wrap_base;
                  alu_in.b = ADDR_WIDTH'(wrap_offset);
               end
               default: begin
                  alu_in.a = req_ff.base_address;
               end
            endcase
         end
         ST_WINDOW: begin
            alu_in.a   = addr_ff;
            alu_in.b   = win_rd.base;
            alu_in.c   = win_rd.span;
            alu_in.sub = 1'b1;
         end
         ST_TABLE: begin
            alu_in.a   = entry_address;
            alu_in.b   = addr_ff;
            alu_in.sub = 1'b1;
         end
         default: begin
            alu_in = '0;
         end
      endcase
   end

   // Next state and datapath updates.
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rem_in       = rem_ff;
      bit_in       = bit_ff;
      addr_in      = addr_ff;
      win_in       = win_ff;
      found_in     = found_ff;
      target_in    = target_ff;
      ent_in       = ent_ff;
      hit_in       = hit_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      probe.check     = 1'b0;
      probe.diff      = alu_out.result;
      probe.beat_size = req_ff.beat_size;

      commit.reserve = 1'b0;
      commit.address = req_ff.base_address;
      commit.size    = req_ff.beat_size;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               rem_in   = '0;
               bit_in   = BIT_IDX_W'(REM_BITS - 1);
               state_in = (req_data.burst_mode == MODE_WRAP) ? ST_REMAIN : ST_ADDRESS;
            end
         end

         // One restoring remainder step per cycle, most significant beat bit first.
         ST_REMAIN: begin
            rem_in = alu_out.result[ADDR_WIDTH] ? rem_shift[REM_BITS-1:0]
                                                : alu_out.result[REM_BITS-1:0];
            bit_in = bit_ff - 1'b1;
            if (bit_ff == '0) begin
               state_in = ST_ADDRESS;
            end
         end

         ST_ADDRESS: begin
            addr_in   = alu_out.result[ADDR_WIDTH-1:0];
            win_in    = '0;
            found_in  = 1'b0;
            target_in = '0;
            state_in  = ST_WINDOW;
         end

         // Windows are tried in order; the first one that holds the address wins.
         ST_WINDOW: begin
            if (alu_out.below) begin
               found_in  = 1'b1;
               target_in = 2'(win_ff);
            end
            if (alu_out.below || (win_ff == WIN_IDX_W'(TARGET_WINDOWS - 1))) begin
               ent_in = '0;
               hit_in = 1'b0;
               if ((req_ff.operation == OP_WRITE) && alu_out.below && page_same) begin
                  state_in = ST_TABLE;
               end else begin
                  state_in = ST_FINISH;
               end
            end else begin
               win_in = win_ff + 1'b1;
            end
         end

         // A decoded write checks each entry for a hit and clears overlaps.
         ST_TABLE: begin
            probe.check = 1'b1;
            hit_in      = hit_ff || entry_hit;
            if (ent_ff == ENT_IDX_W'(RESERVATION_ENTRIES - 1)) begin
               state_in = ST_FINISH;
            end else begin
               ent_in = ent_ff + 1'b1;
            end
         end

         // Hand the result over once the output register is free.
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.beat_address = addr_ff;
               rsp_in.target_index = target_ff;
               rsp_in.address_ok   = addr_ok;
               if (req_ff.operation == OP_READ) begin
                  rsp_in.write_enable = 1'b0;
                  rsp_in.response     = !addr_ok ? RSP_DEC_ERR
                                        : (req_ff.exclusive ? RSP_EXCL_OK : RSP_OK);
                  commit.reserve      = req_ff.exclusive;
               end else if (addr_ok) begin
                  rsp_in.write_enable = !req_ff.exclusive || hit_ff;
                  rsp_in.response     = (req_ff.exclusive && hit_ff) ? RSP_EXCL_OK
                                                                     : RSP_OK;
               end else begin
                  rsp_in.write_enable = 1'b0;
                  rsp_in.response     = RSP_DEC_ERR;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      rem_ff    <= rem_in;
      bit_ff    <= bit_in;
      addr_ff   <= addr_in;
      win_ff    <= win_in;
      found_ff  <= found_in;
      target_ff <= target_in;
      ent_ff    <= ent_in;
      hit_ff    <= hit_in;
      rsp_ff    <= rsp_in;
   end

`ifndef SYNTHESIS
   // A new result only appears right after the finishing step.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_FINISH))
      else $error("result appeared outside the finishing step");

   // A beat that fails decode never enables a write and always reports a decode error.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.address_ok |->
         !rsp_data.write_enable && (rsp_data.response == RSP_DEC_ERR))
      else $error("undecoded beat reported without decode error");

   // Only decoded write beats scan the reservation table.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TABLE) |-> (req_ff.operation == OP_WRITE) && addr_ok)
      else $error("table scan for a beat that is not a decoded write");

   // An exclusive okay implies a decoded address.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.response == RSP_EXCL_OK) |-> rsp_data.address_ok)
      else $error("exclusive okay on an undecoded beat");
`endif

endmodule

`default_nettype wire
